// File: src/neural_activation_function_unit_core_macros.svh
// Assertion macros used by the activation unit checker.
`ifndef NEURAL_ACTIVATION_FUNCTION_UNIT_CORE_MACROS_SVH
`define NEURAL_ACTIVATION_FUNCTION_UNIT_CORE_MACROS_SVH

// Concurrent check, masked while reset is active.
`define NAF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("activation unit check failed");

// Concurrent check that also runs during reset.
`define NAF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("activation unit reset check failed");

`endif

// File: src/naf_pkg.sv
// Package: constants, codes, knot tables and arithmetic helpers of the activation unit.
`default_nettype none
package naf_pkg;

  localparam int SEGMENTS  = 64;
  localparam int FRAC_BITS = 12;
  localparam int SEG_W     = $clog2(SEGMENTS);
  localparam int KNOT_W    = FRAC_BITS + 1;
  localparam int TANH_SPAN = 8 << FRAC_BITS;
  localparam int EXP_SPAN  = 16 << FRAC_BITS;
  localparam int TANH_STEP = TANH_SPAN / SEGMENTS;
  localparam int EXP_STEP  = EXP_SPAN / SEGMENTS;
  localparam int TANH_LG   = $clog2(TANH_STEP);
  localparam int EXP_LG    = $clog2(EXP_STEP);
  localparam int MAG_W     = 21;

  localparam logic signed [17:0] ONE         = 18'sd1 <<< FRAC_BITS;
  localparam logic signed [17:0] K_TENTH     = 18'sd6554;
  localparam logic signed [17:0] K_CUBIC     = 18'sd2930;
  localparam logic signed [17:0] K_SQRT2PI   = 18'sd52290;
  localparam logic signed [17:0] K_ALPHA     = 18'sd109659;
  localparam logic signed [17:0] K_LAMBDA    = 18'sd68859;

  typedef enum logic [3:0] {
    MODE_STEP     = 4'd0,
    MODE_IDENTITY = 4'd1,
    MODE_SIGMOID  = 4'd2,
    MODE_TANH     = 4'd3,
    MODE_RELU     = 4'd4,
    MODE_LEAKY    = 4'd5,
    MODE_ELU      = 4'd6,
    MODE_GELU     = 4'd7,
    MODE_SELU     = 4'd8,
    MODE_SWISH    = 4'd9
  } mode_t;

  typedef struct packed {
    logic             is_exp;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } naf_arg_t;

  typedef logic [KNOT_W-1:0] knot_tab_t [0:SEGMENTS];

  // shift-subtract quotient, used only while building the knot tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-t in Q30 via (e^-(t/16))^16, t in Q(FRAC_BITS)
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
    logic [63:0] u;
    logic [63:0] term;
    logic signed [64:0] sum;
    logic [63:0] e;
    u    = t << (26 - FRAC_BITS);
    term = 64'd1 << 30;
    sum  = 65'sd1 <<< 30;
    if (u > (64'd1 << 30)) u = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv64((term * u) >> 30, 64'(n));
      if ((n & 1) == 1) sum = sum - 65'(term);
      else sum = sum + 65'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (65'sd1 <<< 30)) sum = 65'sd1 <<< 30;
    e = 64'(sum);
    for (int i = 0; i < 4; i++) e = (e * e + (64'd1 << 29)) >> 30;
    return e;
  endfunction

  function automatic knot_tab_t build_knots(input logic is_exp);
    knot_tab_t tab;
    logic [63:0] p;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    for (int k = 0; k <= SEGMENTS; k++) begin
      if (is_exp) begin
        p = 64'(k) * 64'(EXP_STEP);
        e = exp_neg_q30(p);
        tab[k] = KNOT_W'((e + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      end else begin
        p   = 64'(k) * 64'(TANH_STEP);
        e   = exp_neg_q30(2 * p);
        num = (64'd1 << 30) - e;
        den = (64'd1 << 30) + e;
        tab[k] = KNOT_W'(udiv64((num << FRAC_BITS) + (den >> 1), den));
      end
    end
    return tab;
  endfunction

  localparam knot_tab_t TANH_KNOTS = build_knots(1'b0);
  localparam knot_tab_t EXP_KNOTS  = build_knots(1'b1);

  // round half away from zero, then shift right by s
  function automatic logic signed [47:0] rshift_round(input logic signed [47:0] p,
                                                      input logic [5:0] s);
    logic signed [47:0] half;
    half = 48'sd1 <<< (s - 6'd1);
    if (p >= 0) return (p + half) >>> s;
    return -((-p + half) >>> s);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return 16'(v);
  endfunction

endpackage
`default_nettype wire

// File: src/neural_activation_function_unit_core.sv
// Top level: pipelined activation function unit for Q4.12 samples.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_sample (signed 16)
//  out_    | output    | out_valid/out_stall| out_activation (signed 16)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_function_select (4)
//
// Nine register stages; one sample enters per cycle while the output is not stalled.
// The depth is set by the GELU chain: square, cube, two constant multiplies,
// two table stages, one shared multiplier and a final SELU multiply.
// Synchronous active-low reset clears the valid bits and selects identity.
// A stalled output freezes the whole pipeline; in_stall follows it at once.
`default_nettype none
module neural_activation_function_unit_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_activation,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_function_select
);

  localparam int DEPTH = 9;

  logic                   en;
  logic [3:0]             fsel_r;
  logic [DEPTH:1]         v_r;
  logic signed [15:0]     x_r [1:8];
  logic [3:0]             m_r [1:8];

  logic signed [19:0]     sq_nxt, sq_r;
  logic signed [22:0]     cube_nxt, cube_r;
  logic signed [18:0]     c_nxt, c_r;
  logic signed [19:0]     gsum;
  logic signed [20:0]     inner;
  logic signed [20:0]     targ;
  naf_pkg::naf_arg_t      arg_nxt, arg_r;
  logic signed [naf_pkg::KNOT_W:0] th;

  logic signed [17:0]     onepth;
  logic signed [17:0]     mul_a, mul_b;
  logic [5:0]             sh;
  logic                   use_mul;
  logic signed [17:0]     direct;
  logic signed [35:0]     prod8;
  logic signed [17:0]     r8_nxt, r8_r;
  logic signed [47:0]     fin;
  logic signed [15:0]     act_r;

  assign en        = !(v_r[DEPTH] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r <= naf_pkg::MODE_IDENTITY;
      v_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) fsel_r <= cfg_function_select;
      if (en) v_r <= {v_r[DEPTH-1:1], in_valid};
    end
  end

  // sample and mode shift line
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[1] <= in_sample;
      m_r[1] <= fsel_r;
      for (int i = 2; i <= 8; i++) begin
        x_r[i] <= x_r[i-1];
        m_r[i] <= m_r[i-1];
      end
    end
  end

  // GELU cubic: x^2, x^3, 0.044715*x^3
  assign sq_nxt   = 20'(naf_pkg::rshift_round(48'(x_r[1] * x_r[1]), 6'd12));
  assign cube_nxt = 23'(naf_pkg::rshift_round(48'(sq_r * x_r[2]), 6'd12));
  assign c_nxt    = 19'(naf_pkg::rshift_round(48'(cube_r * naf_pkg::K_CUBIC), 6'd16));

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      cube_r <= cube_nxt;
      c_r    <= c_nxt;
    end
  end

  // table argument select
  always_comb begin
    gsum  = 20'(x_r[4]) + 20'(c_r);
    inner = 21'(naf_pkg::rshift_round(48'(gsum * naf_pkg::K_SQRT2PI), 6'd16));
    arg_nxt.is_exp = 1'b0;
    case (m_r[4])
      naf_pkg::MODE_GELU: targ = inner;
      naf_pkg::MODE_SIGMOID,
      naf_pkg::MODE_SWISH: targ = 21'(naf_pkg::rshift_round(48'(x_r[4]), 6'd1));
      naf_pkg::MODE_ELU,
      naf_pkg::MODE_SELU: begin
        targ = -21'(x_r[4]);
        arg_nxt.is_exp = 1'b1;
      end
      default: targ = 21'(x_r[4]);
    endcase
    arg_nxt.neg = targ < 0;
    arg_nxt.mag = arg_nxt.neg ? naf_pkg::MAG_W'(-targ) : naf_pkg::MAG_W'(targ);
  end

  always_ff @(posedge clk) begin
    if (en) arg_r <= arg_nxt;
  end

  naf_pwl u_pwl (
    .clk (clk),
    .en  (en),
    .arg (arg_r),
    .th  (th)
  );

  // shared multiplier per mode
  always_comb begin
    onepth  = naf_pkg::ONE + 18'(th);
    mul_a   = 18'(x_r[7]);
    mul_b   = '0;
    sh      = 6'd16;
    use_mul = 1'b0;
    direct  = 18'(x_r[7]);
    case (m_r[7])
      naf_pkg::MODE_STEP: direct = (x_r[7] < 0) ? 18'sd0 : naf_pkg::ONE;
      naf_pkg::MODE_SIGMOID: begin
        use_mul = 1'b1;
        mul_a   = onepth;
        mul_b   = 18'sd1;
        sh      = 6'd1;
      end
      naf_pkg::MODE_TANH: direct = 18'(th);
      naf_pkg::MODE_RELU: direct = (x_r[7] < 0) ? 18'sd0 : 18'(x_r[7]);
      naf_pkg::MODE_LEAKY: begin
        use_mul = x_r[7] < 0;
        mul_b   = naf_pkg::K_TENTH;
      end
      naf_pkg::MODE_ELU: begin
        use_mul = x_r[7] < 0;
        mul_a   = 18'(th) - naf_pkg::ONE;
        mul_b   = naf_pkg::K_TENTH;
      end
      naf_pkg::MODE_GELU,
      naf_pkg::MODE_SWISH: begin
        use_mul = 1'b1;
        mul_b   = onepth;
        sh      = 6'(naf_pkg::FRAC_BITS + 1);
      end
      naf_pkg::MODE_SELU: begin
        use_mul = 1'b1;
        if (x_r[7] < 0) begin
          mul_a = 18'(th) - naf_pkg::ONE;
          mul_b = naf_pkg::K_ALPHA;
        end else begin
          mul_b = naf_pkg::K_LAMBDA;
        end
      end
      default: direct = 18'(x_r[7]);
    endcase
    prod8  = mul_a * mul_b;
    r8_nxt = use_mul ? 18'(naf_pkg::rshift_round(48'(prod8), sh)) : direct;
  end

  always_ff @(posedge clk) begin
    if (en) r8_r <= r8_nxt;
  end

  // SELU negative side takes a second constant multiply, then saturate
  always_comb begin
    if (m_r[8] == naf_pkg::MODE_SELU && x_r[8] < 0)
      fin = naf_pkg::rshift_round(48'(r8_r * naf_pkg::K_LAMBDA), 6'd16);
    else
      fin = 48'(r8_r);
  end

  always_ff @(posedge clk) begin
    if (en) act_r <= naf_pkg::sat16(fin);
  end

  assign out_valid      = v_r[DEPTH];
  assign out_activation = act_r;

endmodule
`default_nettype wire

// File: src/naf_pwl.sv
// Two-stage piecewise-linear tanh / exp(-a) table evaluator.
`default_nettype none
module naf_pwl (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire naf_pkg::naf_arg_t             arg,
  output logic signed [naf_pkg::KNOT_W:0]    th
);

  localparam int PROD_W = naf_pkg::KNOT_W + naf_pkg::EXP_LG;

  logic                            clamp;
  logic [naf_pkg::SEG_W-1:0]       idx;
  logic [naf_pkg::SEG_W:0]         idx1;
  logic [naf_pkg::EXP_LG-1:0]      frac;
  logic [naf_pkg::KNOT_W-1:0]      v0;
  logic [naf_pkg::KNOT_W-1:0]      v1;
  logic signed [naf_pkg::KNOT_W:0] diff;
  logic [naf_pkg::KNOT_W-1:0]      dmag;
  logic [PROD_W-1:0]               prod_nxt;

  logic [naf_pkg::KNOT_W-1:0]      v0_r;
  logic                            dneg_r;
  logic [PROD_W-1:0]               prod_r;
  logic                            exp_r;
  logic                            neg_r;

  logic [PROD_W-1:0]               stp;
  logic signed [naf_pkg::KNOT_W:0] val;
  logic signed [naf_pkg::KNOT_W:0] th_nxt;
  logic signed [naf_pkg::KNOT_W:0] th_r;

  always_comb begin
    if (arg.is_exp) begin
      clamp = arg.mag >= naf_pkg::MAG_W'(naf_pkg::EXP_SPAN);
      idx   = arg.mag[naf_pkg::EXP_LG +: naf_pkg::SEG_W];
      frac  = arg.mag[naf_pkg::EXP_LG-1:0];
    end else begin
      clamp = arg.mag >= naf_pkg::MAG_W'(naf_pkg::TANH_SPAN);
      idx   = arg.mag[naf_pkg::TANH_LG +: naf_pkg::SEG_W];
      frac  = naf_pkg::EXP_LG'(arg.mag[naf_pkg::TANH_LG-1:0]);
    end
    idx1 = {1'b0, idx} + 1'b1;
    if (clamp) begin
      v0 = arg.is_exp ? naf_pkg::EXP_KNOTS[naf_pkg::SEGMENTS]
                      : naf_pkg::TANH_KNOTS[naf_pkg::SEGMENTS];
      v1 = v0;
    end else begin
      v0 = arg.is_exp ? naf_pkg::EXP_KNOTS[{1'b0, idx}] : naf_pkg::TANH_KNOTS[{1'b0, idx}];
      v1 = arg.is_exp ? naf_pkg::EXP_KNOTS[idx1] : naf_pkg::TANH_KNOTS[idx1];
    end
    diff     = $signed({1'b0, v1}) - $signed({1'b0, v0});
    dmag     = diff[naf_pkg::KNOT_W] ? naf_pkg::KNOT_W'(-diff) : naf_pkg::KNOT_W'(diff);
    prod_nxt = PROD_W'(dmag) * PROD_W'(frac);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r   <= v0;
      dneg_r <= diff[naf_pkg::KNOT_W];
      prod_r <= prod_nxt;
      exp_r  <= arg.is_exp;
      neg_r  <= arg.neg;
    end
  end

  always_comb begin
    if (exp_r) stp = (prod_r + (PROD_W'(1) << (naf_pkg::EXP_LG - 1))) >> naf_pkg::EXP_LG;
    else stp = (prod_r + (PROD_W'(1) << (naf_pkg::TANH_LG - 1))) >> naf_pkg::TANH_LG;
    if (dneg_r) val = $signed({1'b0, v0_r}) - $signed((naf_pkg::KNOT_W + 1)'(stp));
    else val = $signed({1'b0, v0_r}) + $signed((naf_pkg::KNOT_W + 1)'(stp));
    // tanh is odd: mirror for negative arguments
    th_nxt = neg_r ? -val : val;
  end

  always_ff @(posedge clk) begin
    if (en) th_r <= th_nxt;
  end

  assign th = th_r;

endmodule
`default_nettype wire

// File: src/naf_checker.sv
// Port-level checker for the activation unit, bound to the top level.
`default_nettype none
`include "neural_activation_function_unit_core_macros.svh"
module naf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [15:0] in_sample,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_activation,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  // stalled result holds
  `NAF_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_activation)))
  // input backs up only behind a stalled result
  `NAF_ASSERT(a_in_stall_cause, in_stall |-> (out_valid && out_stall))
  // stalled input transfer keeps its payload
  `NAF_ASSERT(a_in_hold, (in_valid && in_stall) |=> (in_valid && $stable(in_sample)))
  // configuration write is taken at once
  `NAF_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)
  // reset drops pending results
  `NAF_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid)

endmodule

bind neural_activation_function_unit_core naf_checker u_naf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_sample      (in_sample),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_activation (out_activation),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
`default_nettype wire
